/* sv/tplm_pkg.sv */
// Shared types and constants for the telemetry poll link master.
// Used by tplm_front, tplm_queue, tplm_back and the top level; no dependencies.
`timescale 1ns / 1ps

package tplm_pkg;

  // input item kinds (s_tuser)
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_POLL  = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_SLOT   = 2'd1;
  localparam logic [1:0] KIND_REQ    = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_PREAMBLE = 3'd1;
  localparam logic [2:0] ST_BAD_CHECK    = 3'd2;
  localparam logic [2:0] ST_BUSY         = 3'd3;
  localparam logic [2:0] ST_TIMEOUT      = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_PREAMBLE    = 3'd0;
  localparam logic [2:0] REG_LIVE_MOTION = 3'd1;
  localparam logic [2:0] REG_HIST_MOTION = 3'd2;
  localparam logic [2:0] REG_LIVE_RATE   = 3'd3;
  localparam logic [2:0] REG_HIST_RATE   = 3'd4;
  localparam logic [2:0] REG_PUSH_INFO   = 3'd5;
  localparam logic [2:0] REG_TIMEOUT     = 3'd6;

  // register reset values
  localparam logic [7:0]  RST_PREAMBLE    = 8'd170;
  localparam logic [15:0] RST_LIVE_MOTION = 16'd1;
  localparam logic [15:0] RST_HIST_MOTION = 16'd2;
  localparam logic [15:0] RST_LIVE_RATE   = 16'd3;
  localparam logic [15:0] RST_HIST_RATE   = 16'd4;
  localparam logic [15:0] RST_PUSH_INFO   = 16'd5;
  localparam logic [15:0] RST_TIMEOUT     = 16'd100;

  // first slot of each telemetry group
  localparam logic [3:0] SLOT_PITCH     = 4'd0;
  localparam logic [3:0] SLOT_PEAKS     = 4'd2;
  localparam logic [3:0] SLOT_MAX_G     = 4'd4;
  localparam logic [3:0] SLOT_GYRO      = 4'd6;
  localparam logic [3:0] SLOT_GYRO_PEAK = 4'd9;

  // board number sent in every request
  localparam logic [7:0] TX_BOARD_ID = 8'd1;

  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  // what follows the slot results of an item
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_STATUS,
    TAIL_REQ
  } tail_t;

  // one classified item: everything the back end needs to emit its results
  typedef struct packed {
    logic [2:0]         n_slots;
    logic [3:0]         slot_base;
    logic signed [15:0] word_a;
    logic signed [15:0] word_b;
    logic signed [15:0] word_c;
    logic signed [15:0] word_d;
    tail_t              tail;
    logic [2:0]         status;
    logic [15:0]        tx_opcode;
    logic [7:0]         tx_check;
    logic               cycle_busy;
    logic               link_waiting;
  } plan_t;

endpackage

/* sv/telemetry_poll_link_master.sv */
// Top level of the telemetry poll link master: stream ports, config port.
// Depends on tplm_pkg, tplm_front, tplm_queue and tplm_back.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries input words: tuser is the item kind (tick, poll wake-up,
//   received frame), tdata the received frame fields. m_axis carries result
//   words: tuser is the result kind, tdata the other result fields, tlast set
//   on the final result of each input word. The cfg channel writes one
//   register per handshake (cfg_ready is always high); write only while the
//   block is idle.
// Timing:
//   The front end takes one input word per cycle while the plan queue has
//   room (QUEUE_DEPTH entries). The first result of a word is offered once
//   its plan, registered in the queue, reaches the queue head; a word makes
//   1 to 5 results, one per cycle while m_tready is high, so sustained
//   throughput is set by the back end.
// Reset:
//   rst (synchronous) restores register defaults, clears link and cycle
//   state, and empties the queue.
// Stall:
//   If m_tready is low the current result holds; the queue fills and then
//   s_tready drops until results drain.

module telemetry_poll_link_master_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  // configuration write
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  // input stream
  input  logic          s_tvalid,
  output logic          s_tready,
  // [7:0] rx_preamble, [15:8] rx_board, [31:16] rx_opcode, [39:32] rx_motor,
  // [55:40] rx_word_a, [71:56] rx_word_b, [87:72] rx_word_c,
  // [103:88] rx_word_d, [111:104] rx_check
  input  logic [111:0]  s_tdata,
  // [1:0] command
  input  logic [1:0]    s_tuser,
  // output stream
  output logic          m_tvalid,
  input  logic          m_tready,
  // [3:0] slot, [19:4] slot_value, [27:20] tx_board, [43:28] tx_opcode,
  // [51:44] tx_check, [54:52] status, [55] cycle_busy, [56] link_waiting,
  // [63:57] zero
  output logic [63:0]   m_tdata,
  // [1:0] kind
  output logic [1:0]    m_tuser,
  output logic          m_tlast
);

  logic               push, push_ready, pop, head_valid;
  tplm_pkg::plan_t    push_plan, head_plan;

  logic [1:0]         kind;
  logic [3:0]         slot;
  logic signed [15:0] slot_value;
  logic [7:0]         tx_board;
  logic [15:0]        tx_opcode;
  logic [7:0]         tx_check;
  logic [2:0]         status;
  logic               cycle_busy, link_waiting;

  tplm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .command     (s_tuser),
    .rx_preamble (s_tdata[7:0]),
    .rx_board    (s_tdata[15:8]),
    .rx_opcode   (s_tdata[31:16]),
    .rx_motor    (s_tdata[39:32]),
    .rx_word_a   (s_tdata[55:40]),
    .rx_word_b   (s_tdata[71:56]),
    .rx_word_c   (s_tdata[87:72]),
    .rx_word_d   (s_tdata[103:88]),
    .rx_check    (s_tdata[111:104]),
    .push        (push),
    .push_ready  (push_ready),
    .plan        (push_plan)
  );

  tplm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_plan  (push_plan),
    .pop        (pop),
    .head_valid (head_valid),
    .head_plan  (head_plan)
  );

  tplm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_plan    (head_plan),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .kind         (kind),
    .slot         (slot),
    .slot_value   (slot_value),
    .tx_board     (tx_board),
    .tx_opcode    (tx_opcode),
    .tx_check     (tx_check),
    .status       (status),
    .cycle_busy   (cycle_busy),
    .link_waiting (link_waiting),
    .last         (m_tlast)
  );

  // pack result fields, lowest first; the kind travels on tuser
  assign m_tuser = kind;
  assign m_tdata = {7'd0, link_waiting, cycle_busy, status, tx_check, tx_opcode,
                    tx_board, slot_value, slot};

endmodule

/* sv/tplm_front.sv */
// Front end: configuration registers, link state, and classification of each
// input word into a result plan. Depends on tplm_pkg.
`timescale 1ns / 1ps

module tplm_front (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input item
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [7:0]         rx_preamble,
  input  logic [7:0]         rx_board,
  input  logic [15:0]        rx_opcode,
  input  logic [7:0]         rx_motor,
  input  logic signed [15:0] rx_word_a,
  input  logic signed [15:0] rx_word_b,
  input  logic signed [15:0] rx_word_c,
  input  logic signed [15:0] rx_word_d,
  input  logic [7:0]         rx_check,
  // plan toward the queue
  output logic               push,
  input  logic               push_ready,
  output tplm_pkg::plan_t    plan
);

  // configuration
  logic [7:0]  preamble_value;
  logic [15:0] code_live_motion;
  logic [15:0] code_hist_motion;
  logic [15:0] code_live_rate;
  logic [15:0] code_hist_rate;
  logic [15:0] code_push_info;
  logic [15:0] timeout_ticks;

  // link state
  logic        awaiting_reply, awaiting_reply_next;
  logic        cycle_active, cycle_active_next;
  logic [15:0] wait_elapsed, wait_elapsed_next;

  logic [7:0]  frame_xor;
  logic [15:0] elapsed_inc;
  logic        aw_freed;
  logic        do_send;
  logic [15:0] send_code;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;
  assign push      = in_valid & push_ready;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_value   <= tplm_pkg::RST_PREAMBLE;
      code_live_motion <= tplm_pkg::RST_LIVE_MOTION;
      code_hist_motion <= tplm_pkg::RST_HIST_MOTION;
      code_live_rate   <= tplm_pkg::RST_LIVE_RATE;
      code_hist_rate   <= tplm_pkg::RST_HIST_RATE;
      code_push_info   <= tplm_pkg::RST_PUSH_INFO;
      timeout_ticks    <= tplm_pkg::RST_TIMEOUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        tplm_pkg::REG_PREAMBLE:    preamble_value   <= cfg_data[7:0];
        tplm_pkg::REG_LIVE_MOTION: code_live_motion <= cfg_data;
        tplm_pkg::REG_HIST_MOTION: code_hist_motion <= cfg_data;
        tplm_pkg::REG_LIVE_RATE:   code_live_rate   <= cfg_data;
        tplm_pkg::REG_HIST_RATE:   code_hist_rate   <= cfg_data;
        tplm_pkg::REG_PUSH_INFO:   code_push_info   <= cfg_data;
        tplm_pkg::REG_TIMEOUT:     timeout_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // XOR over every header and data byte of the frame
  assign frame_xor = rx_preamble ^ rx_board ^ rx_opcode[15:8] ^ rx_opcode[7:0] ^ rx_motor
                   ^ rx_word_a[15:8] ^ rx_word_a[7:0] ^ rx_word_b[15:8] ^ rx_word_b[7:0]
                   ^ rx_word_c[15:8] ^ rx_word_c[7:0] ^ rx_word_d[15:8] ^ rx_word_d[7:0];

  assign elapsed_inc = (wait_elapsed == tplm_pkg::WAIT_MAX) ? wait_elapsed
                                                            : wait_elapsed + 16'd1;

  // a nonzero board number frees the link before the next request is tried
  assign aw_freed = (rx_board != 8'd0) ? 1'b0 : awaiting_reply;

  // classification and next state
  always_comb begin
    awaiting_reply_next = awaiting_reply;
    cycle_active_next   = cycle_active;
    wait_elapsed_next   = wait_elapsed;
    do_send             = 1'b0;
    send_code           = 16'd0;

    plan.n_slots      = 3'd0;
    plan.slot_base    = tplm_pkg::SLOT_PITCH;
    plan.word_a       = rx_word_a;
    plan.word_b       = rx_word_b;
    plan.word_c       = rx_word_c;
    plan.word_d       = rx_word_d;
    plan.tail         = tplm_pkg::TAIL_STATUS;
    plan.status       = tplm_pkg::ST_OK;
    plan.tx_opcode    = 16'd0;
    plan.tx_check     = 8'd0;

    case (command)
      tplm_pkg::CMD_TICK: begin
        if (awaiting_reply) begin
          wait_elapsed_next = elapsed_inc;
          if (elapsed_inc > timeout_ticks) begin
            awaiting_reply_next = 1'b0;
            cycle_active_next   = 1'b0;
            plan.status         = tplm_pkg::ST_TIMEOUT;
          end
        end
      end
      tplm_pkg::CMD_POLL: begin
        if (!awaiting_reply && !cycle_active) begin
          cycle_active_next = 1'b1;
          do_send           = 1'b1;
          send_code         = code_live_motion;
        end
      end
      tplm_pkg::CMD_FRAME: begin
        if (rx_preamble != preamble_value) begin
          plan.status = tplm_pkg::ST_BAD_PREAMBLE;
        end else if (frame_xor != rx_check) begin
          plan.status = tplm_pkg::ST_BAD_CHECK;
        end else begin
          awaiting_reply_next = aw_freed;
          if (rx_opcode == code_live_motion) begin
            plan.n_slots   = 3'd2;
            plan.slot_base = tplm_pkg::SLOT_PITCH;
            do_send        = 1'b1;
            send_code      = code_hist_motion;
          end else if (rx_opcode == code_hist_motion) begin
            plan.n_slots   = 3'd4;
            plan.slot_base = tplm_pkg::SLOT_PEAKS;
            do_send        = 1'b1;
            send_code      = code_live_rate;
          end else if (rx_opcode == code_live_rate) begin
            plan.n_slots   = 3'd3;
            plan.slot_base = tplm_pkg::SLOT_GYRO;
            do_send        = 1'b1;
            send_code      = code_hist_rate;
          end else if (rx_opcode == code_hist_rate) begin
            plan.n_slots   = 3'd3;
            plan.slot_base = tplm_pkg::SLOT_GYRO_PEAK;
            do_send        = 1'b1;
            send_code      = code_push_info;
          end else if (rx_opcode == code_push_info) begin
            plan.n_slots      = 3'd2;
            plan.slot_base    = tplm_pkg::SLOT_MAX_G;
            plan.tail         = tplm_pkg::TAIL_NONE;
            cycle_active_next = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // request attempt: refused while still waiting on a reply
    if (do_send) begin
      if (awaiting_reply_next) begin
        cycle_active_next = 1'b0;
        plan.status       = tplm_pkg::ST_BUSY;
      end else begin
        awaiting_reply_next = 1'b1;
        wait_elapsed_next   = 16'd0;
        plan.tail           = tplm_pkg::TAIL_REQ;
        plan.tx_opcode      = send_code;
        plan.tx_check       = preamble_value ^ tplm_pkg::TX_BOARD_ID
                            ^ send_code[15:8] ^ send_code[7:0];
      end
    end

    plan.cycle_busy   = cycle_active_next;
    plan.link_waiting = awaiting_reply_next;
  end

  // link state
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_reply <= 1'b0;
      cycle_active   <= 1'b0;
      wait_elapsed   <= 16'd0;
    end else if (push) begin
      awaiting_reply <= awaiting_reply_next;
      cycle_active   <= cycle_active_next;
      wait_elapsed   <= wait_elapsed_next;
    end
  end

endmodule

/* sv/tplm_queue.sv */
// Plan queue between the front and back ends, a small circular buffer.
// Depends on tplm_pkg for plan_t.
`timescale 1ns / 1ps

module tplm_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            push_ready,
  input  tplm_pkg::plan_t push_plan,
  input  logic            pop,
  output logic            head_valid,
  output tplm_pkg::plan_t head_plan
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tplm_pkg::plan_t   store [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_plan  = store[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_plan;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

/* sv/tplm_back.sv */
// Back end: walks the plan at the queue head and emits one result per cycle while out_ready is high.
// Depends on tplm_pkg.
`timescale 1ns / 1ps

module tplm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  tplm_pkg::plan_t    head_plan,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [3:0]         slot,
  output logic signed [15:0] slot_value,
  output logic [7:0]         tx_board,
  output logic [15:0]        tx_opcode,
  output logic [7:0]         tx_check,
  output logic [2:0]         status,
  output logic               cycle_busy,
  output logic               link_waiting,
  output logic               last
);

  // index of the result being offered within the current plan
  logic [2:0] idx;
  logic [2:0] total;
  logic       take;

  assign total = head_plan.n_slots
               + ((head_plan.tail != tplm_pkg::TAIL_NONE) ? 3'd1 : 3'd0);
  assign last      = (idx == total - 3'd1);
  assign out_valid = head_valid;
  assign take      = head_valid & out_ready;
  assign pop       = take & last;

  assign cycle_busy   = head_plan.cycle_busy;
  assign link_waiting = head_plan.link_waiting;

  // result fields
  always_comb begin
    kind       = tplm_pkg::KIND_STATUS;
    slot       = 4'd0;
    slot_value = 16'sd0;
    tx_board   = 8'd0;
    tx_opcode  = 16'd0;
    tx_check   = 8'd0;
    status     = tplm_pkg::ST_OK;
    if (idx < head_plan.n_slots) begin
      kind = tplm_pkg::KIND_SLOT;
      slot = head_plan.slot_base + {2'b00, idx[1:0]};
      case (idx[1:0])
        2'd0:    slot_value = head_plan.word_a;
        2'd1:    slot_value = head_plan.word_b;
        2'd2:    slot_value = head_plan.word_c;
        default: slot_value = head_plan.word_d;
      endcase
    end else if (head_plan.tail == tplm_pkg::TAIL_REQ) begin
      kind      = tplm_pkg::KIND_REQ;
      tx_board  = tplm_pkg::TX_BOARD_ID;
      tx_opcode = head_plan.tx_opcode;
      tx_check  = head_plan.tx_check;
    end else begin
      status = head_plan.status;
    end
  end

  // step through the plan, back to zero on its last result
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (take) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

/* tb/tplm_checker.sv */
// Scoreboard for telemetry_poll_link_master_core: watches the config, input and result
// channels, predicts the result words of every accepted input word and compares them.
// Depends on tplm_pkg.
`timescale 1ns / 1ps

module tplm_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [111:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  output int           fail_count,
  output int           outstanding,
  output int           words_seen,
  output int           results_seen,
  output int           requests_seen,
  output int           timeouts_seen,
  output int           refusals_seen
);

  // one result word, split into its fields
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] slot_value;
    logic [7:0]  tx_board;
    logic [15:0] tx_opcode;
    logic [7:0]  tx_check;
    logic [2:0]  status;
    logic        cycle_busy;
    logic        link_waiting;
    logic        last;
  } poll_result_t;

  // register copy
  logic [7:0]  preamble_reg;
  logic [15:0] live_motion_code;
  logic [15:0] hist_motion_code;
  logic [15:0] live_rate_code;
  logic [15:0] hist_rate_code;
  logic [15:0] push_info_code;
  logic [15:0] timeout_reg;

  // link state copy
  logic        awaiting_reply;
  logic        cycle_on;
  logic [15:0] wait_ticks;

  poll_result_t expected_results[$];
  poll_result_t word_results[$];
  poll_result_t want;

  // queue one result of the current word; busy/waiting/last are filled in later
  function automatic void emit(logic [1:0] kind, logic [3:0] slot, logic [15:0] value,
                               logic [15:0] opcode, logic [2:0] status);
    poll_result_t r;
    r = '0;
    r.kind = kind;
    r.status = status;
    if (kind == tplm_pkg::KIND_SLOT) begin
      r.slot = slot;
      r.slot_value = value;
    end
    if (kind == tplm_pkg::KIND_REQ) begin
      r.tx_board = tplm_pkg::TX_BOARD_ID;
      r.tx_opcode = opcode;
      r.tx_check = preamble_reg ^ tplm_pkg::TX_BOARD_ID ^ opcode[15:8] ^ opcode[7:0];
    end
    word_results.push_back(r);
  endfunction

  // a request goes out only if the link is free; otherwise the cycle is dropped
  function automatic void try_request(logic [15:0] opcode);
    if (awaiting_reply) begin
      cycle_on = 1'b0;
      emit(tplm_pkg::KIND_STATUS, '0, '0, '0, tplm_pkg::ST_BUSY);
    end else begin
      awaiting_reply = 1'b1;
      wait_ticks = '0;
      emit(tplm_pkg::KIND_REQ, '0, '0, opcode, tplm_pkg::ST_OK);
    end
  endfunction

  function automatic void take_frame(logic [111:0] d);
    logic [7:0]  sum;
    logic [15:0] opc;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [15:0] wc;
    logic [15:0] wd;
    // checksum is the XOR of every byte ahead of the check byte
    sum = '0;
    for (int i = 0; i < 13; i++) sum ^= d[8*i +: 8];
    opc = d[31:16];
    wa = d[55:40];
    wb = d[71:56];
    wc = d[87:72];
    wd = d[103:88];
    if (d[7:0] != preamble_reg) begin
      emit(tplm_pkg::KIND_STATUS, '0, '0, '0, tplm_pkg::ST_BAD_PREAMBLE);
    end else if (sum != d[111:104]) begin
      emit(tplm_pkg::KIND_STATUS, '0, '0, '0, tplm_pkg::ST_BAD_CHECK);
    end else begin
      // broadcast replies leave the link waiting
      if (d[15:8] != 8'd0) awaiting_reply = 1'b0;
      // first matching code register wins
      if (opc == live_motion_code) begin
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_PITCH, wa, '0, tplm_pkg::ST_OK);
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_PITCH + 4'd1, wb, '0, tplm_pkg::ST_OK);
        try_request(hist_motion_code);
      end else if (opc == hist_motion_code) begin
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_PEAKS, wa, '0, tplm_pkg::ST_OK);
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_PEAKS + 4'd1, wb, '0, tplm_pkg::ST_OK);
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_MAX_G, wc, '0, tplm_pkg::ST_OK);
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_MAX_G + 4'd1, wd, '0, tplm_pkg::ST_OK);
        try_request(live_rate_code);
      end else if (opc == live_rate_code) begin
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_GYRO, wa, '0, tplm_pkg::ST_OK);
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_GYRO + 4'd1, wb, '0, tplm_pkg::ST_OK);
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_GYRO + 4'd2, wc, '0, tplm_pkg::ST_OK);
        try_request(hist_rate_code);
      end else if (opc == hist_rate_code) begin
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_GYRO_PEAK, wa, '0, tplm_pkg::ST_OK);
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_GYRO_PEAK + 4'd1, wb, '0,
             tplm_pkg::ST_OK);
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_GYRO_PEAK + 4'd2, wc, '0,
             tplm_pkg::ST_OK);
        try_request(push_info_code);
      end else if (opc == push_info_code) begin
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_MAX_G, wa, '0, tplm_pkg::ST_OK);
        emit(tplm_pkg::KIND_SLOT, tplm_pkg::SLOT_MAX_G + 4'd1, wb, '0, tplm_pkg::ST_OK);
        cycle_on = 1'b0;
      end else begin
        emit(tplm_pkg::KIND_STATUS, '0, '0, '0, tplm_pkg::ST_OK);
      end
    end
  endfunction

  // work out all result words of one input word and append them
  function automatic void predict_word(logic [1:0] cmd, logic [111:0] d);
    logic [2:0]   st;
    poll_result_t r;
    word_results.delete();
    case (cmd)
      tplm_pkg::CMD_TICK: begin
        st = tplm_pkg::ST_OK;
        if (awaiting_reply) begin
          if (wait_ticks != tplm_pkg::WAIT_MAX) wait_ticks++;
          if (wait_ticks > timeout_reg) begin
            awaiting_reply = 1'b0;
            cycle_on = 1'b0;
            st = tplm_pkg::ST_TIMEOUT;
            timeouts_seen++;
          end
        end
        emit(tplm_pkg::KIND_STATUS, '0, '0, '0, st);
      end
      tplm_pkg::CMD_POLL: begin
        if (!awaiting_reply && !cycle_on) begin
          cycle_on = 1'b1;
          try_request(live_motion_code);
        end else begin
          emit(tplm_pkg::KIND_STATUS, '0, '0, '0, tplm_pkg::ST_OK);
        end
      end
      tplm_pkg::CMD_FRAME: take_frame(d);
      default: emit(tplm_pkg::KIND_STATUS, '0, '0, '0, tplm_pkg::ST_OK);
    endcase
    for (int k = 0; k < word_results.size(); k++) begin
      r = word_results[k];
      r.cycle_busy = cycle_on;
      r.link_waiting = awaiting_reply;
      r.last = (k == word_results.size() - 1);
      if (r.kind == tplm_pkg::KIND_REQ) requests_seen++;
      if (r.kind == tplm_pkg::KIND_STATUS && r.status == tplm_pkg::ST_BUSY) refusals_seen++;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      preamble_reg <= tplm_pkg::RST_PREAMBLE;
      live_motion_code <= tplm_pkg::RST_LIVE_MOTION;
      hist_motion_code <= tplm_pkg::RST_HIST_MOTION;
      live_rate_code <= tplm_pkg::RST_LIVE_RATE;
      hist_rate_code <= tplm_pkg::RST_HIST_RATE;
      push_info_code <= tplm_pkg::RST_PUSH_INFO;
      timeout_reg <= tplm_pkg::RST_TIMEOUT;
      awaiting_reply <= 1'b0;
      cycle_on <= 1'b0;
      wait_ticks <= '0;
      expected_results.delete();
    end else begin
      // result side: compare against the oldest expectation
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, got %h user %h last %b",
                   $time, m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, m_tuser);
          check_field("slot", want.slot, m_tdata[3:0]);
          check_field("slot_value", want.slot_value, m_tdata[19:4]);
          check_field("tx_board", want.tx_board, m_tdata[27:20]);
          check_field("tx_opcode", want.tx_opcode, m_tdata[43:28]);
          check_field("tx_check", want.tx_check, m_tdata[51:44]);
          check_field("status", want.status, m_tdata[54:52]);
          check_field("cycle_busy", want.cycle_busy, m_tdata[55]);
          check_field("link_waiting", want.link_waiting, m_tdata[56]);
          check_field("tdata pad", '0, m_tdata[63:57]);
          check_field("tlast", want.last, m_tlast);
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tplm_pkg::REG_PREAMBLE:    preamble_reg = cfg_data[7:0];
          tplm_pkg::REG_LIVE_MOTION: live_motion_code = cfg_data;
          tplm_pkg::REG_HIST_MOTION: hist_motion_code = cfg_data;
          tplm_pkg::REG_LIVE_RATE:   live_rate_code = cfg_data;
          tplm_pkg::REG_HIST_RATE:   hist_rate_code = cfg_data;
          tplm_pkg::REG_PUSH_INFO:   push_info_code = cfg_data;
          tplm_pkg::REG_TIMEOUT:     timeout_reg = cfg_data;
          default: ;
        endcase
      end
      // input side
      if (s_tvalid && s_tready) begin
        words_seen++;
        predict_word(s_tuser, s_tdata);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the telemetry_poll_link_master_core testbench: clock, reset, stimulus, verdict.
// Depends on tplm_pkg, telemetry_poll_link_master_core and tplm_checker.
`timescale 1ns / 1ps

module testbench;

  // input kind the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_WORDS = 115;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  int fail_count;
  int outstanding;
  int words_seen;
  int results_seen;
  int requests_seen;
  int timeouts_seen;
  int refusals_seen;

  int src_idle_pct;
  int sink_idle_pct;
  int hold_req;
  int hold_done;

  // shadow of the registers, used to build well-formed frames
  logic [7:0]  cur_pre;
  logic [15:0] cur_code [5];
  int unsigned poll_stage;

  telemetry_poll_link_master_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  tplm_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .words_seen    (words_seen),
    .results_seen  (results_seen),
    .requests_seen (requests_seen),
    .timeouts_seen (timeouts_seen),
    .refusals_seen (refusals_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("** telemetry_poll_link_master_core: FAILED **");
    $finish;
  end

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic logic [111:0] rand112();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[111:0];
  endfunction

  // frame fields packed with a correct checksum byte
  function automatic logic [111:0] sealed(logic [7:0] pre, logic [7:0] board,
                                           logic [15:0] opc, logic [7:0] motor,
                                           logic [15:0] a, logic [15:0] b,
                                           logic [15:0] c, logic [15:0] d);
    logic [111:0] f;
    logic [7:0]   sum;
    f = {8'h00, d, c, b, a, motor, opc, board, pre};
    sum = '0;
    for (int i = 0; i < 13; i++) sum ^= f[8*i +: 8];
    f[111:104] = sum;
    return f;
  endfunction

  // offer one input word, with a random gap ahead of it
  task automatic put_word(logic [1:0] cmd, logic [111:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(logic [7:0] pre, logic [15:0] c0, logic [15:0] c1,
                           logic [15:0] c2, logic [15:0] c3, logic [15:0] c4,
                           logic [15:0] tmo);
    write_reg(tplm_pkg::REG_PREAMBLE, {8'h00, pre});
    write_reg(tplm_pkg::REG_LIVE_MOTION, c0);
    write_reg(tplm_pkg::REG_HIST_MOTION, c1);
    write_reg(tplm_pkg::REG_LIVE_RATE, c2);
    write_reg(tplm_pkg::REG_HIST_RATE, c3);
    write_reg(tplm_pkg::REG_PUSH_INFO, c4);
    write_reg(tplm_pkg::REG_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
    cur_pre = pre;
    cur_code[0] = c0;
    cur_code[1] = c1;
    cur_code[2] = c2;
    cur_code[3] = c3;
    cur_code[4] = c4;
    poll_stage = 5;
  endtask

  // stop offering, wait for every expected result, then let the block go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly the next reply of a poll cycle, with ticks, polls and broken frames mixed in
  task automatic random_step(output bit counted);
    int unsigned  pick;
    logic [111:0] f;
    pick = $urandom_range(99);
    f = sealed(cur_pre, 8'($urandom_range(255, 1)), cur_code[poll_stage % 5],
               8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    counted = 1'b1;
    if (poll_stage >= 5 || pick < 8) begin
      put_word(tplm_pkg::CMD_POLL, rand112());
      poll_stage = 0;
    end else if (pick < 18) begin
      put_word(tplm_pkg::CMD_TICK, rand112());
    end else if (pick < 22) begin
      f[7:0] = cur_pre ^ 8'($urandom_range(255, 1));
      put_word(tplm_pkg::CMD_FRAME, f);
    end else if (pick < 26) begin
      f[111:104] ^= 8'($urandom_range(255, 1));
      put_word(tplm_pkg::CMD_FRAME, f);
    end else if (pick < 29) begin
      // broadcast reply: clear the board byte and fix up the checksum
      f[111:104] ^= f[15:8];
      f[15:8] = 8'h00;
      put_word(tplm_pkg::CMD_FRAME, f);
    end else if (pick < 31) begin
      put_word(CMD_UNUSED, rand112());
      counted = 1'b0;
    end else if (pick < 35) begin
      put_word(tplm_pkg::CMD_FRAME, rand112());
    end else begin
      put_word(tplm_pkg::CMD_FRAME, f);
      poll_stage++;
    end
  endtask

  task automatic run_phase(int n);
    int done;
    bit counted;
    done = 0;
    while (done < n) begin
      random_step(counted);
      if (counted) done++;
    end
  endtask

  // stimulus
  initial begin
    logic [111:0] f;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tuser <= '0;
    s_tdata <= '0;
    sink_idle_pct <= 49;
    hold_req <= 0;
    src_idle_pct = 13;
    cur_pre = tplm_pkg::RST_PREAMBLE;
    cur_code[0] = tplm_pkg::RST_LIVE_MOTION;
    cur_code[1] = tplm_pkg::RST_HIST_MOTION;
    cur_code[2] = tplm_pkg::RST_LIVE_RATE;
    cur_code[3] = tplm_pkg::RST_HIST_RATE;
    cur_code[4] = tplm_pkg::RST_PUSH_INFO;
    poll_stage = 5;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset register values
    put_word(tplm_pkg::CMD_TICK, '0);       // tick while idle
    put_word(CMD_UNUSED, '1);               // ignored kind
    put_word(tplm_pkg::CMD_FRAME, sealed(~cur_pre, 8'h01, cur_code[0], 8'h00,
                                         16'h0001, 16'h0002, 16'h0003, 16'h0004));
    f = sealed(cur_pre, 8'h01, cur_code[0], 8'h00, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
    f[111:104] ^= 8'h80;
    put_word(tplm_pkg::CMD_FRAME, f);       // bad checksum
    put_word(tplm_pkg::CMD_POLL, '0);       // starts a cycle
    put_word(tplm_pkg::CMD_POLL, '0);       // poll while busy
    put_word(tplm_pkg::CMD_TICK, '0);
    // broadcast reply keeps the link waiting, so the next request is refused
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h00, cur_code[0], 8'hFF,
                                         16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
    // full cycle, extreme data words
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'hFF, cur_code[0], 8'h00,
                                         16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000));
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h01, cur_code[1], 8'hFF,
                                         16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001));
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h80, cur_code[2], 8'h3C,
                                         16'h1234, 16'hEDCB, 16'h8001, 16'h7FFE));
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h7F, cur_code[3], 8'hC3,
                                         16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA));
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h01, cur_code[4], 8'h01,
                                         16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF));
    // unknown codes
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h02, 16'hFFFF, 8'h00,
                                         16'h0000, 16'h0000, 16'h0000, 16'h0000));
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h02, 16'h0000, 8'hFF,
                                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // a reply outside any cycle still sends the next request
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h05, cur_code[2], 8'h00,
                                         16'h0101, 16'h0202, 16'h0303, 16'h0404));
    put_word(tplm_pkg::CMD_POLL, '0);
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h01, cur_code[4], 8'h00,
                                         16'h0011, 16'h0022, 16'h0033, 16'h0044));
    settle();

    // short timeout, duplicate codes, zero preamble
    configure(8'h00, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'd1);
    put_word(tplm_pkg::CMD_POLL, '0);
    put_word(tplm_pkg::CMD_TICK, '0);
    put_word(tplm_pkg::CMD_TICK, '0);       // times out
    put_word(tplm_pkg::CMD_POLL, '0);
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h80, 16'hFFFF, 8'h00,
                                         16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
    put_word(tplm_pkg::CMD_FRAME, sealed(cur_pre, 8'h01, 16'h0000, 8'h00,
                                         16'h0001, 16'hFFFE, 16'h8000, 16'h0000));
    put_word(tplm_pkg::CMD_FRAME, sealed(8'hFF, 8'h01, 16'h8000, 8'h00,
                                         16'h0000, 16'h0000, 16'h0000, 16'h0000));
    settle();

    // random, sender idles a little, receiver a lot
    configure(8'h5A, 16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h7FFE, 16'd40);
    run_phase(PHASE_WORDS);
    settle();

    // random, the other way round, short timeout
    configure(8'hFF, 16'h00A5, 16'h5A00, 16'hC3C3, 16'h3C3C, 16'h0F0F, 16'd3);
    src_idle_pct = 49;
    sink_idle_pct <= 13;
    run_phase(PHASE_WORDS);
    settle();

    // random, no idling, timeout disabled, one long receiver hold-off
    configure(tplm_pkg::RST_PREAMBLE, tplm_pkg::RST_LIVE_MOTION, tplm_pkg::RST_HIST_MOTION,
              tplm_pkg::RST_LIVE_RATE, tplm_pkg::RST_HIST_RATE, tplm_pkg::RST_PUSH_INFO,
              16'hFFFF);
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    hold_req <= hold_req + 1;
    run_phase(PHASE_WORDS);
    settle();

    $display("Covered %0d input words and %0d result words (%0d requests, %0d timeouts,",
             words_seen, results_seen, requests_seen, timeouts_seen);
    $display("%0d refused sends) over five register settings and three stall patterns.",
             refusals_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** telemetry_poll_link_master_core: PASSED **");
    end else begin
      $display("** telemetry_poll_link_master_core: FAILED **");
    end
    $finish;
  end

endmodule
